>>> hdl/critically_damped_follow_defines.svh
// Assertion macros for the critically damped follow block.
// Used by the top level; needs a clk and an active-low rst_n in scope.
`ifndef CRITICALLY_DAMPED_FOLLOW_DEFINES_SVH
`define CRITICALLY_DAMPED_FOLLOW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cdf_pkg.sv
// Package for the critically damped follow block: sequencer types,
// register indexes and saturating helpers. Depends on nothing.
package cdf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_WB,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        STEP_OMEGA,
        STEP_X,
        STEP_X2,
        STEP_X3,
        STEP_D48,
        STEP_D235,
        STEP_E,
        STEP_OX,
        STEP_TX,
        STEP_OY,
        STEP_TY,
        STEP_VX0,
        STEP_VX,
        STEP_VY0,
        STEP_VY,
        STEP_NX,
        STEP_NY
    } step_t;

    localparam logic [2:0] REG_SMOOTH_TIME = 3'd0;
    localparam logic [2:0] REG_HAS_TARGET  = 3'd1;
    localparam logic [2:0] REG_TARGET_X    = 3'd2;
    localparam logic [2:0] REG_TARGET_Y    = 3'd3;

    localparam logic [5:0] MUL_LAST = 6'd61;
    localparam logic [5:0] DIV_LAST = 6'd63;

    localparam logic signed [63:0] CAP = 64'sd1 <<< 61;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    function automatic logic signed [63:0] clampc(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > CAP) r = CAP;
        if (v < -CAP) r = -CAP;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > I32_MAX) r = I32_MAX;
        if (v < I32_MIN) r = I32_MIN;
        return r[31:0];
    endfunction

    function automatic logic signed [63:0] uadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        return (s > CAP) ? CAP : s;
    endfunction

endpackage

>>> hdl/critically_damped_follow.sv
// Top level of the critically damped follow block: sequencer, shared
// bit-serial multiplier and divider. Depends on cdf_pkg and the defines header.
`include "critically_damped_follow_defines.svh"

// Critically damped follow. Each accepted item (time step and 2D position)
// yields one result item. When no target is set or the time step is zero the
// position passes through unchanged. Otherwise the block runs a
// fixed sequence of two divisions and fifteen multiplications on one shared
// shift-and-add multiplier (one multiplier bit per cycle) and one
// restoring divider (one quotient bit per cycle), with a setup state and a
// write-back state around each operation. The multiplier and divider loops
// take most of an item's time. A new item is taken as soon as the sequencer
// is back at rest, even while the last result still waits in the output
// register. Configuration writes land at once and should only be made while
// the block is at rest.
module critically_damped_follow #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [23:0]        time_step,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic               updated
);
    import cdf_pkg::*;

    // Constants that follow from the fraction width.
    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint ST_RAW = (ONE_L + 500) / 1000;
    localparam longint ST_MIN = (ST_RAW != 0) ? ST_RAW : 1;
    localparam longint C48_L  = ((longint'(48) << FRAC_BITS) + 50) / 100;
    localparam longint C235_L = ((longint'(235) << FRAC_BITS) + 500) / 1000;
    localparam logic signed [63:0] ONE_Q  = 64'(ONE_L);
    localparam logic signed [63:0] C48    = 64'(C48_L);
    localparam logic signed [63:0] C235   = 64'(C235_L);
    localparam logic [23:0]        ST_LOW = 24'(ST_MIN);
    localparam logic [61:0]        HALF_Q = 62'(1) << (FRAC_BITS - 1);
    localparam logic [63:0]        NUM_OM = 64'(2) << (2 * FRAC_BITS);
    localparam logic [63:0]        NUM_E  = 64'(1) << (2 * FRAC_BITS);

    // Configuration registers.
    logic [23:0]        smooth_time_reg;
    logic               has_target_reg;
    logic signed [31:0] target_x_reg;
    logic signed [31:0] target_y_reg;

    // Kept velocity.
    logic signed [31:0] vel_x_reg;
    logic signed [31:0] vel_y_reg;

    // Sequencer.
    state_t      state_reg, state_next;
    step_t       step_reg;
    logic [5:0]  cnt_reg;

    // Item and intermediate values.
    logic [23:0]        dt_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [63:0] om_reg, xr_reg, x2_reg, x3_reg, d_reg, e_reg;
    logic signed [63:0] t_reg, tx_reg, ty_reg, nvx_reg, nvy_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic               upd_reg;

    // Multiplier: magnitudes, accumulator and low product half.
    logic [61:0] ma_reg, mb_reg, acc_reg, lo_reg;
    logic        neg_reg;

    // Divider.
    logic [63:0] num_reg, q_reg;
    logic [61:0] den_reg, rem_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               out_upd_reg;

    logic in_take, skip, out_free, is_div, last_step;
    logic signed [63:0] op_a, op_b, mres;
    logic [63:0] div_num;
    logic [61:0] div_den;
    logic [62:0] msum, dshift;
    logic [123:0] prod, rfull;
    logic [61:0] umag;
    logic [23:0] st_eff;
    logic signed [63:0] dx_w, dy_w;

    assign in_take   = in_valid && in_ready;
    assign skip      = !has_target_reg || (time_step == 24'd0);
    assign out_free  = !out_valid_reg || out_ready;
    assign is_div    = (step_reg == STEP_OMEGA) || (step_reg == STEP_E);
    assign last_step = (step_reg == STEP_NY);
    assign st_eff    = (smooth_time_reg == 24'd0) ? ST_LOW : smooth_time_reg;
    assign dx_w      = 64'(dx_reg);
    assign dy_w      = 64'(dy_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            STEP_X:    begin op_a = om_reg;                     op_b = 64'(dt_reg); end
            STEP_X2:   begin op_a = xr_reg;                     op_b = xr_reg;      end
            STEP_X3:   begin op_a = x2_reg;                     op_b = xr_reg;      end
            STEP_D48:  begin op_a = C48;                        op_b = x2_reg;      end
            STEP_D235: begin op_a = C235;                       op_b = x3_reg;      end
            STEP_OX:   begin op_a = om_reg;                     op_b = dx_w;        end
            STEP_TX:   begin op_a = clampc(64'(vel_x_reg) + t_reg); op_b = 64'(dt_reg); end
            STEP_OY:   begin op_a = om_reg;                     op_b = dy_w;        end
            STEP_TY:   begin op_a = clampc(64'(vel_y_reg) + t_reg); op_b = 64'(dt_reg); end
            STEP_VX0:  begin op_a = om_reg;                     op_b = tx_reg;      end
            STEP_VX:   begin op_a = clampc(64'(vel_x_reg) - t_reg); op_b = e_reg;   end
            STEP_VY0:  begin op_a = om_reg;                     op_b = ty_reg;      end
            STEP_VY:   begin op_a = clampc(64'(vel_y_reg) - t_reg); op_b = e_reg;   end
            STEP_NX:   begin op_a = clampc(dx_w + tx_reg);      op_b = e_reg;       end
            STEP_NY:   begin op_a = clampc(dy_w + ty_reg);      op_b = e_reg;       end
            default:   begin op_a = '0;                         op_b = '0;          end
        endcase
    end

    // Rounded numerators and divisors for the two divisions.
    always_comb
    begin
        if (step_reg == STEP_OMEGA)
        begin
            div_num = NUM_OM + 64'(st_eff[23:1]);
            div_den = 62'(st_eff);
        end
        else
        begin
            div_num = NUM_E + {1'b0, d_reg[63:1]};
            div_den = d_reg[61:0];
        end
    end

    // One multiplier bit and one quotient bit per cycle.
    assign msum   = {1'b0, acc_reg} + (mb_reg[0] ? {1'b0, ma_reg} : 63'd0);
    assign dshift = {rem_reg, num_reg[63]};

    // Product already carries the rounding half; shift, cap, restore sign.
    assign prod  = {acc_reg, lo_reg};
    assign rfull = prod >> FRAC_BITS;
    assign umag  = ((|rfull[123:62]) || ({1'b0, rfull[61:0]} > 63'(CAP))) ?
                   CAP[61:0] : rfull[61:0];
    assign mres  = neg_reg ? -64'(umag) : 64'(umag);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = skip ? ST_OUT : ST_START;
            ST_START: state_next = is_div ? ST_DIV : ST_MUL;
            ST_MUL:   if (cnt_reg == MUL_LAST) state_next = ST_WB;
            ST_DIV:   if (cnt_reg == DIV_LAST) state_next = ST_WB;
            ST_WB:    state_next = last_step ? ST_OUT : ST_START;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
        new_pos_x = out_x_reg;
        new_pos_y = out_y_reg;
        updated   = out_upd_reg;
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_OMEGA;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            smooth_time_reg <= 24'd19661;
            has_target_reg  <= 1'b0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            vel_x_reg       <= '0;
            vel_y_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SMOOTH_TIME: smooth_time_reg <= cfg_data[23:0];
                    REG_HAS_TARGET:  has_target_reg  <= cfg_data[0];
                    REG_TARGET_X:    target_x_reg    <= cfg_data;
                    REG_TARGET_Y:    target_y_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            if (in_take) step_reg <= STEP_OMEGA;
            if (state_reg == ST_START) cnt_reg <= '0;
            else if (state_reg == ST_MUL || state_reg == ST_DIV) cnt_reg <= cnt_reg + 6'd1;
            if (state_reg == ST_WB)
            begin
                if (!last_step) step_reg <= step_t'(step_reg + 5'd1);
                else
                begin
                    vel_x_reg <= sat32(nvx_reg);
                    vel_y_reg <= sat32(nvy_reg);
                end
            end
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dt_reg  <= time_step;
            dx_reg  <= 33'(pos_x) - 33'(target_x_reg);
            dy_reg  <= 33'(pos_y) - 33'(target_y_reg);
            nx_reg  <= pos_x;
            ny_reg  <= pos_y;
            upd_reg <= !skip;
        end
        unique case (state_reg)
            ST_START:
            begin
                ma_reg  <= op_a[63] ? 62'(-op_a) : op_a[61:0];
                mb_reg  <= op_b[63] ? 62'(-op_b) : op_b[61:0];
                neg_reg <= op_a[63] ^ op_b[63];
                acc_reg <= HALF_Q;
                lo_reg  <= '0;
                num_reg <= div_num;
                den_reg <= div_den;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            ST_MUL:
            begin
                acc_reg <= msum[62:1];
                lo_reg  <= {msum[0], lo_reg[61:1]};
                mb_reg  <= {1'b0, mb_reg[61:1]};
            end
            ST_DIV:
            begin
                num_reg <= {num_reg[62:0], 1'b0};
                if (dshift >= {1'b0, den_reg})
                begin
                    rem_reg <= 62'(dshift - {1'b0, den_reg});
                    q_reg   <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dshift[61:0];
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
            end
            ST_WB:
            begin
                unique case (step_reg)
                    STEP_OMEGA: om_reg  <= q_reg;
                    STEP_X:     xr_reg  <= mres;
                    STEP_X2:    x2_reg  <= mres;
                    STEP_X3:    x3_reg  <= mres;
                    STEP_D48:   d_reg   <= uadd(uadd(ONE_Q, xr_reg), mres);
                    STEP_D235:  d_reg   <= uadd(d_reg, mres);
                    STEP_E:     e_reg   <= q_reg;
                    STEP_TX:    tx_reg  <= mres;
                    STEP_TY:    ty_reg  <= mres;
                    STEP_VX:    nvx_reg <= mres;
                    STEP_VY:    nvy_reg <= mres;
                    STEP_NX:    nx_reg  <= sat32(64'(target_x_reg) + mres);
                    STEP_NY:    ny_reg  <= sat32(64'(target_y_reg) + mres);
                    default:    t_reg   <= mres;
                endcase
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_x_reg   <= nx_reg;
                    out_y_reg   <= ny_reg;
                    out_upd_reg <= upd_reg;
                end
            end
            default: ;
        endcase
    end

    // The sequencer takes no item while it is busy.
    `CDF_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !in_ready, "ready while busy")
    // Every accepted item leaves the rest state.
    `CDF_ASSERT_NXT(a_take_leaves_idle, in_take, state_reg != ST_IDLE, "item not started")
    // A finished item waits while the output register is still held.
    `CDF_ASSERT_NXT(a_out_holds, state_reg == ST_OUT && out_valid_reg && !out_ready,
                    state_reg == ST_OUT, "result dropped under stall")

endmodule

>>> verif/tb_critically_damped_follow.sv
// Self-checking testbench for critically_damped_follow: drives tick items with
// random gaps and stalls and checks each result against a fixed-point predictor.
// Depends on cdf_pkg and the critically_damped_follow RTL.
module tb_critically_damped_follow;
    timeunit 1ns;
    timeprecision 1ps;

    import cdf_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] SAT_CAP = 64'h2000_0000_0000_0000;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
    // 0.001 s, 0.48 and 0.235 rounded to the fraction width.
    localparam logic [63:0] ST_FLOOR = 64'd66;
    localparam logic [63:0] K48 = 64'd31457;
    localparam logic [63:0] K235 = 64'd15401;
    localparam int SETTLE_CYCLES = 1500;
    localparam int CYCLE_LIMIT = 12000000;

    typedef struct {
        logic [23:0]        dt;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } tick_t;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic               upd;
    } follow_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [23:0]        time_step;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic               updated;

    critically_damped_follow u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .time_step (time_step),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .new_pos_x (new_pos_x),
        .new_pos_y (new_pos_y),
        .updated   (updated)
    );

    // Mirror of the block's configuration and velocity state.
    logic [23:0] smooth_time_q;
    logic        has_target_q;
    longint      target_x_q;
    longint      target_y_q;
    longint      vel_x_q;
    longint      vel_y_q;

    tick_t   ticks_pending[$];
    follow_t follow_expected[$];
    int      errors;
    int      cycles;
    int      results_seen;
    int      damped_seen;
    int      idle_pct;
    logic    took;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Unsigned product scaled down by the fraction width, rounded, capped.
    function automatic logic [63:0] umul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC - 1));
        if (p[127:80] != 0)
            return SAT_CAP;
        if (p[79:16] > SAT_CAP)
            return SAT_CAP;
        return p[79:16];
    endfunction

    // Signed version: magnitude product, rounding half away from zero.
    function automatic longint smul_q(input longint a, input longint b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        r = umul_q(ua, ub);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] uadd_cap(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SAT_CAP) ? SAT_CAP : s;
    endfunction

    function automatic longint cap61(input longint v);
        if (v > longint'(SAT_CAP))
            return longint'(SAT_CAP);
        if (v < -longint'(SAT_CAP))
            return -longint'(SAT_CAP);
        return v;
    endfunction

    function automatic longint sat_q32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // One smoothing step; a damped step updates the mirrored velocity.
    function automatic follow_t damp_step(input tick_t t);
        follow_t     r;
        logic [63:0] st;
        logic [63:0] omega;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] d;
        logic [63:0] e;
        longint      dx;
        longint      dy;
        longint      tx;
        longint      ty;
        longint      vx;
        longint      vy;
        if (!has_target_q || t.dt == 0)
        begin
            r.nx = t.px;
            r.ny = t.py;
            r.upd = 1'b0;
            return r;
        end
        st = (smooth_time_q != 0) ? {40'd0, smooth_time_q} : ST_FLOOR;
        omega = ((64'd2 << (2 * FRAC)) + st / 2) / st;
        x = umul_q(omega, {40'd0, t.dt});
        x2 = umul_q(x, x);
        x3 = umul_q(x2, x);
        d = uadd_cap(ONE_Q, x);
        d = uadd_cap(d, umul_q(K48, x2));
        d = uadd_cap(d, umul_q(K235, x3));
        e = ((ONE_Q << FRAC) + d / 2) / d;
        dx = longint'(t.px) - target_x_q;
        dy = longint'(t.py) - target_y_q;
        tx = smul_q(cap61(vel_x_q + smul_q(longint'(omega), dx)), longint'(t.dt));
        ty = smul_q(cap61(vel_y_q + smul_q(longint'(omega), dy)), longint'(t.dt));
        vx = smul_q(cap61(vel_x_q - smul_q(longint'(omega), tx)), longint'(e));
        vy = smul_q(cap61(vel_y_q - smul_q(longint'(omega), ty)), longint'(e));
        r.nx = 32'(sat_q32(target_x_q + smul_q(cap61(dx + tx), longint'(e))));
        r.ny = 32'(sat_q32(target_y_q + smul_q(cap61(dy + ty), longint'(e))));
        r.upd = 1'b1;
        vel_x_q = sat_q32(vx);
        vel_y_q = sat_q32(vy);
        return r;
    endfunction

    // Driver, accept side: an item is taken at the rising edge of a handshake,
    // and its expected result is worked out right then against the current
    // configuration, which only changes while the block is at rest.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            follow_expected.push_back(damp_step(ticks_pending[0]));
            ticks_pending.pop_front();
        end
    end

    // Driver, present side: an item stays on the port until it is taken. Once
    // taken, the next one is offered unless a random gap is drawn.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !took))
        begin
            if (ticks_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                time_step <= ticks_pending[0].dt;
                pos_x <= ticks_pending[0].px;
                pos_y <= ticks_pending[0].py;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Monitor: compares each result item with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (follow_expected.size() == 0)
            begin
                $error("unexpected result item: new_pos_x %0d new_pos_y %0d updated %0b",
                       new_pos_x, new_pos_y, updated);
                errors++;
            end
            else
            begin
                if (new_pos_x !== follow_expected[0].nx)
                begin
                    $error("new_pos_x expected %0d actual %0d", follow_expected[0].nx, new_pos_x);
                    errors++;
                end
                if (new_pos_y !== follow_expected[0].ny)
                begin
                    $error("new_pos_y expected %0d actual %0d", follow_expected[0].ny, new_pos_y);
                    errors++;
                end
                if (updated !== follow_expected[0].upd)
                begin
                    $error("updated expected %0b actual %0b", follow_expected[0].upd, updated);
                    errors++;
                end
                if (follow_expected[0].upd)
                    damped_seen++;
                follow_expected.pop_front();
                results_seen++;
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Register write: one cycle with the write enable high, mirrored at once.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_SMOOTH_TIME: smooth_time_q = val[23:0];
            REG_HAS_TARGET:  has_target_q = val[0];
            REG_TARGET_X:    target_x_q = longint'($signed(val));
            REG_TARGET_Y:    target_y_q = longint'($signed(val));
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every item is taken and every result is back, then lets
    // the sequencer finish whatever it might still be doing.
    task automatic drain_block();
        while (ticks_pending.size() != 0 || follow_expected.size() != 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick(input logic [23:0] dt, input logic [31:0] px,
                             input logic [31:0] py);
        tick_t t;
        t.dt = dt;
        t.px = px;
        t.py = py;
        ticks_pending.push_back(t);
    endtask

    // Random tick: mostly small steps near the target so the spring actually
    // settles over a run, with full-range steps and positions mixed in.
    task automatic push_random_tick();
        logic [23:0] dt;
        logic [31:0] px;
        logic [31:0] py;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            dt = 24'd0;
        else if (pick < 75)
            dt = 24'($urandom_range(1, 24'h4000));
        else
            dt = 24'($urandom);
        if ($urandom_range(0, 99) < 70)
        begin
            px = 32'(target_x_q + longint'($signed(32'($urandom_range(0, 32'h0010_0000)))) -
                     longint'(32'h0008_0000));
            py = 32'(target_y_q + longint'($urandom_range(0, 32'h0010_0000)) -
                     longint'(32'h0008_0000));
        end
        else
        begin
            px = $urandom;
            py = $urandom;
        end
        push_tick(dt, px, py);
    endtask

    initial
    begin
        logic [31:0] st_val;
        int          ph;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        time_step = '0;
        pos_x = '0;
        pos_y = '0;
        took = 1'b0;
        errors = 0;
        cycles = 0;
        results_seen = 0;
        damped_seen = 0;
        idle_pct = 20;
        smooth_time_q = 24'd19661;
        has_target_q = 1'b0;
        target_x_q = 0;
        target_y_q = 0;
        vel_x_q = 0;
        vel_y_q = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration has no target, so every item passes through.
        push_tick(24'h00_4000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_tick(24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_tick(24'd0, 32'h0001_0000, 32'hFFFF_0000);
        drain_block();

        // Target at the origin, zero smoothing time (the 0.001 s floor).
        cfg_write(REG_HAS_TARGET, 32'd1);
        cfg_write(REG_SMOOTH_TIME, 32'd0);
        push_tick(24'd1, 32'h0010_0000, 32'hFFF0_0000);
        push_tick(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_tick(24'd0, 32'h1234_5678, 32'h8765_4321);
        push_tick(24'h00_0444, 32'h0000_0000, 32'h0000_0000);
        drain_block();

        // Longest smoothing time and targets at the range corners, so the
        // result saturates and the exponential term nears one.
        cfg_write(REG_SMOOTH_TIME, 32'hFFFF_FFFF);
        cfg_write(REG_TARGET_X, 32'h7FFF_FFFF);
        cfg_write(REG_TARGET_Y, 32'h8000_0000);
        push_tick(24'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        push_tick(24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_tick(24'h01_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_tick(24'h80_0000, 32'h0000_0000, 32'h0000_0000);
        drain_block();

        // Shortest nonzero smoothing time, an ignored index, then the motion
        // freeze with velocity still stored, then release.
        cfg_write(REG_SMOOTH_TIME, 32'd1);
        cfg_write(3'd6, 32'hFFFF_FFFF);
        push_tick(24'd1, 32'h0000_0001, 32'hFFFF_FFFF);
        push_tick(24'h00_0010, 32'hC000_0000, 32'h4000_0000);
        drain_block();
        cfg_write(REG_HAS_TARGET, 32'hFFFF_FFFE);
        push_tick(24'h00_1000, 32'h0001_0000, 32'h0002_0000);
        drain_block();
        cfg_write(REG_HAS_TARGET, 32'hFFFF_FFFF);
        cfg_write(REG_SMOOTH_TIME, 32'd19661);
        push_tick(24'h00_1000, 32'h0001_0000, 32'h0002_0000);
        push_tick(24'h00_1000, 32'h0001_0000, 32'h0002_0000);
        drain_block();

        // Random phases, each with its own setting. Phase 2 runs with no
        // idling at all; in phase 4 the sender stops midway for a full drain.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: st_val = 32'd0;
                1: st_val = 32'h00FF_FFFF;
                2: st_val = 32'd1;
                default: st_val = (ph % 2) ? $urandom : 32'($urandom_range(1000, 200000));
            endcase
            cfg_write(REG_SMOOTH_TIME, st_val);
            cfg_write(REG_HAS_TARGET, (ph == 5) ? 32'd0 : $urandom | 32'd1);
            cfg_write(REG_TARGET_X, (ph == 3) ? 32'h8000_0000 : $urandom);
            cfg_write(REG_TARGET_Y, (ph == 3) ? 32'h7FFF_FFFF : $urandom);
            if ($urandom_range(0, 1))
                cfg_write(3'($urandom_range(4, 7)), $urandom);
            idle_pct = (ph == 2) ? 0 : 20;
            repeat (100) push_random_tick();
            if (ph == 4)
            begin
                while (ticks_pending.size() != 0 || follow_expected.size() != 0)
                    @(posedge clk);
            end
            repeat (100) push_random_tick();
            drain_block();
        end

        $display("Checked %0d result items, %0d of them damped steps, over 8 random settings.",
                 results_seen, damped_seen);
        $display("Covered pass-through, zero smoothing time, range extremes and saturation.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cdf_pkg.sv
hdl/critically_damped_follow.sv
verif/tb_critically_damped_follow.sv
